// File: rtl/assert_macros.svh
// Assertion macros for the clock and calendar set editor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on the rising clock edge, skipped while reset is low.
`define CCSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check an implication on the rising clock edge, skipped while reset is low.
`define CCSE_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

`else

`define CCSE_ASSERT(lbl, prop, msg)
`define CCSE_ASSERT_IMP(lbl, pre, post, msg)

`endif

`endif

// File: rtl/ccse_pkg.sv
// Types, codes and constants of the clock and calendar set editor.
`default_nettype none

package ccse_pkg;

  typedef enum logic [3:0] {
    STEP_WEEKDAY = 4'd0,
    STEP_HOUR    = 4'd1,
    STEP_MINUTE  = 4'd2,
    STEP_SECOND  = 4'd3,
    STEP_YEAR    = 4'd4,
    STEP_MONTH   = 4'd5,
    STEP_DATE    = 4'd6,
    STEP_SAVE    = 4'd7,
    STEP_BACK    = 4'd8
  } step_e;

  localparam int unsigned BtnUp     = 0;
  localparam int unsigned BtnDown   = 1;
  localparam int unsigned BtnSwitch = 2;
  localparam int unsigned BtnBack   = 3;
  localparam int unsigned BtnSave   = 4;

  localparam logic [3:0] BlinkTicksRst = 4'd10;

  localparam logic [6:0] WeekdayMin = 7'd1;
  localparam logic [6:0] WeekdayMax = 7'd7;
  localparam logic [6:0] HourMax    = 7'd23;
  localparam logic [6:0] MinSecMax  = 7'd59;
  localparam logic [6:0] YearMax    = 7'd99;
  localparam logic [6:0] MonthMin   = 7'd1;
  localparam logic [6:0] MonthMax   = 7'd12;
  localparam logic [6:0] DateMin    = 7'd1;

  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthApr = 4'd4;
  localparam logic [3:0] MonthJun = 4'd6;
  localparam logic [3:0] MonthSep = 4'd9;
  localparam logic [3:0] MonthNov = 4'd11;

  localparam logic [4:0] DaysLong  = 5'd31;
  localparam logic [4:0] DaysShort = 5'd30;
  localparam logic [4:0] DaysLeap  = 5'd29;
  localparam logic [4:0] DaysFeb   = 5'd28;

  localparam logic [2:0] RegBlinkTicks = 3'd0;

  typedef struct packed {
    logic [2:0] weekday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] date;
  } edit_t;

  typedef struct packed {
    logic       action;
    logic [4:0] buttons;
    logic [2:0] rtc_weekday;
    logic [4:0] rtc_hour;
    logic [5:0] rtc_minute;
    logic [5:0] rtc_second;
    logic [6:0] rtc_year;
    logic [3:0] rtc_month;
    logic [4:0] rtc_date;
  } in_t;

  typedef struct packed {
    logic [2:0] weekday_value;
    logic [4:0] hour_value;
    logic [5:0] minute_value;
    logic [5:0] second_value;
    logic [6:0] year_value;
    logic [3:0] month_value;
    logic [4:0] date_value;
    logic [3:0] field_selected;
    logic       field_shown;
    logic       commit_time;
    logic       leave_setup;
  } out_t;

endpackage

`default_nettype wire

// File: rtl/ccse_cfg_regs.sv
// Configuration register file with an APB-style access port.
`default_nettype none

module ccse_cfg_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [3:0]  blink_ticks_o
);
  import ccse_pkg::*;

  logic [3:0] blink_ticks_q;
  logic       sel_blink;

  assign sel_blink = (paddr[2] == RegBlinkTicks[2]);
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_ticks_q <= BlinkTicksRst;
    end else if (psel && penable && pwrite && sel_blink) begin
      blink_ticks_q <= pwdata[3:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_blink) begin
      prdata = {28'd0, blink_ticks_q};
    end
  end

  assign blink_ticks_o = blink_ticks_q;

endmodule

`default_nettype wire

// File: rtl/ccse_field_unit.sv
// Up and down wrap of the selected edit field.
`default_nettype none

module ccse_field_unit (
  input  ccse_pkg::step_e step_i,
  input  logic            up_i,
  input  logic            down_i,
  input  ccse_pkg::edit_t edit_i,
  output ccse_pkg::edit_t edit_o
);
  import ccse_pkg::*;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic [6:0] year);
    logic [4:0] len;
    len = DaysLong;
    if (month == MonthApr || month == MonthJun || month == MonthSep || month == MonthNov) begin
      len = DaysShort;
    end else if (month == MonthFeb) begin
      len = (year[1:0] == 2'b00) ? DaysLeap : DaysFeb;
    end
    return len;
  endfunction

  logic [6:0] val;
  logic [6:0] lo;
  logic [6:0] hi;
  logic [6:0] val_up;
  logic [6:0] val_dn;

  always_comb begin
    val = '0;
    lo  = '0;
    hi  = '0;
    case (step_i)
      STEP_WEEKDAY: begin
        val = {4'd0, edit_i.weekday};
        lo  = WeekdayMin;
        hi  = WeekdayMax;
      end
      STEP_HOUR: begin
        val = {2'd0, edit_i.hour};
        hi  = HourMax;
      end
      STEP_MINUTE: begin
        val = {1'b0, edit_i.minute};
        hi  = MinSecMax;
      end
      STEP_SECOND: begin
        val = {1'b0, edit_i.second};
        hi  = MinSecMax;
      end
      STEP_YEAR: begin
        val = edit_i.year;
        hi  = YearMax;
      end
      STEP_MONTH: begin
        val = {3'd0, edit_i.month};
        lo  = MonthMin;
        hi  = MonthMax;
      end
      default: begin
        val = {2'd0, edit_i.date};
        lo  = DateMin;
        hi  = {2'd0, month_len(edit_i.month, edit_i.year)};
      end
    endcase

    val_up = val;
    if (up_i) begin
      val_up = (val >= hi) ? lo : val + 7'd1;
    end
    val_dn = val_up;
    if (down_i) begin
      val_dn = (val_up <= lo || val_up > hi) ? hi : val_up - 7'd1;
    end

    edit_o = edit_i;
    case (step_i)
      STEP_WEEKDAY: edit_o.weekday = val_dn[2:0];
      STEP_HOUR:    edit_o.hour    = val_dn[4:0];
      STEP_MINUTE:  edit_o.minute  = val_dn[5:0];
      STEP_SECOND:  edit_o.second  = val_dn[5:0];
      STEP_YEAR:    edit_o.year    = val_dn;
      STEP_MONTH:   edit_o.month   = val_dn[3:0];
      STEP_DATE:    edit_o.date    = val_dn[4:0];
      default:      edit_o = edit_i;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/clock_calendar_set_editor_core.sv
// Top level of the clock and calendar set editor.
//
//   port group   direction  handshake            payload
//   in_*         in         in_valid_i/in_stall_o  ccse_pkg::in_t word
//   out_*        out        out_valid_o/out_stall_i ccse_pkg::out_t word
//   apb          in/out     psel/penable/pready  blink_ticks at byte address 0
//
// One word is taken per cycle while the input is not stalled; its result sits in the output register in the next cycle.
// All editing is one pass of compare-and-wrap logic from the state registers.
// A stalled result holds the output register and stalls the input side.
// Reset is asynchronous and active low; no clearing pass follows it.
`default_nettype none

`include "assert_macros.svh"

module clock_calendar_set_editor_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ccse_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ccse_pkg::out_t  out_data_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import ccse_pkg::*;

  logic [3:0] blink_ticks;

  step_e      step_q, step_d;
  edit_t      edit_q, edit_d, edit_fu;
  logic [3:0] cnt_q, cnt_d;
  logic       on_q, on_d;
  out_t       out_q, out_d;
  logic       out_valid_q;

  logic       accept;
  logic       shown;
  logic       commit;
  logic       leave;
  logic [3:0] cnt_base;
  logic [4:0] cnt_sum;

  ccse_cfg_regs u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .blink_ticks_o (blink_ticks)
  );

  ccse_field_unit u_field (
    .step_i (step_q),
    .up_i   (in_data_i.buttons[BtnUp]),
    .down_i (in_data_i.buttons[BtnDown]),
    .edit_i (edit_q),
    .edit_o (edit_fu)
  );

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    step_d   = step_q;
    edit_d   = edit_q;
    cnt_d    = cnt_q;
    on_d     = on_q;
    cnt_base = cnt_q;
    cnt_sum  = '0;
    shown    = 1'b0;
    commit   = 1'b0;
    leave    = 1'b0;

    if (!in_data_i.action) begin
      edit_d.weekday = in_data_i.rtc_weekday;
      edit_d.hour    = in_data_i.rtc_hour;
      edit_d.minute  = in_data_i.rtc_minute;
      edit_d.second  = in_data_i.rtc_second;
      edit_d.year    = in_data_i.rtc_year;
      edit_d.month   = in_data_i.rtc_month;
      edit_d.date    = in_data_i.rtc_date;
      step_d         = STEP_WEEKDAY;
      cnt_d          = '0;
      on_d           = 1'b0;
    end else begin
      case (step_q)
        STEP_WEEKDAY, STEP_HOUR, STEP_MINUTE, STEP_SECOND,
        STEP_YEAR, STEP_MONTH, STEP_DATE: begin
          edit_d = edit_fu;
          if (in_data_i.buttons[BtnSwitch]) begin
            step_d   = (step_q == STEP_DATE) ? STEP_WEEKDAY : step_e'(step_q + 4'd1);
            cnt_base = '0;
          end
          if (in_data_i.buttons[BtnBack]) begin
            step_d = STEP_BACK;
          end
          if (in_data_i.buttons[BtnSave]) begin
            step_d = STEP_SAVE;
          end
        end
        STEP_SAVE: begin
          commit = 1'b1;
          leave  = 1'b1;
          step_d = STEP_WEEKDAY;
        end
        STEP_BACK: begin
          leave  = 1'b1;
          step_d = STEP_WEEKDAY;
        end
        default: step_d = step_q;
      endcase

      cnt_d = cnt_base;
      if (step_d <= STEP_DATE) begin
        shown   = on_q;
        cnt_sum = {1'b0, cnt_base} + 5'd1;
        if (cnt_sum >= {1'b0, blink_ticks}) begin
          cnt_d = '0;
          on_d  = ~on_q;
        end else begin
          cnt_d = cnt_sum[3:0];
        end
      end else begin
        shown = 1'b1;
      end
    end

    out_d.weekday_value  = edit_d.weekday;
    out_d.hour_value     = edit_d.hour;
    out_d.minute_value   = edit_d.minute;
    out_d.second_value   = edit_d.second;
    out_d.year_value     = edit_d.year;
    out_d.month_value    = edit_d.month;
    out_d.date_value     = edit_d.date;
    out_d.field_selected = step_d;
    out_d.field_shown    = shown;
    out_d.commit_time    = commit;
    out_d.leave_setup    = leave;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q         <= STEP_WEEKDAY;
      edit_q.weekday <= 3'd1;
      edit_q.hour    <= '0;
      edit_q.minute  <= '0;
      edit_q.second  <= '0;
      edit_q.year    <= '0;
      edit_q.month   <= 4'd1;
      edit_q.date    <= 5'd1;
      cnt_q          <= '0;
      on_q           <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (accept) begin
        step_q      <= step_d;
        edit_q      <= edit_d;
        cnt_q       <= cnt_d;
        on_q        <= on_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CCSE_ASSERT_IMP(a_stall_needs_word, in_stall_o, out_valid_o, "input stalled with no word held")
  `CCSE_ASSERT_IMP(a_commit_leaves, out_valid_o && out_data_o.commit_time, out_data_o.leave_setup && out_data_o.field_selected == STEP_WEEKDAY, "commit without leave")
  `CCSE_ASSERT(a_load_blank, (accept && !in_data_i.action) |=> (out_valid_o && !out_data_o.field_shown && out_data_o.field_selected == STEP_WEEKDAY), "load word result wrong")

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Testbench for the clock and calendar set editor: predicted words checked against the block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ccse_pkg::*;

  localparam logic ActLoad = 1'b0;
  localparam logic ActTick = 1'b1;

  localparam logic [4:0] PressUp     = 5'(1 << BtnUp);
  localparam logic [4:0] PressDown   = 5'(1 << BtnDown);
  localparam logic [4:0] PressSwitch = 5'(1 << BtnSwitch);
  localparam logic [4:0] PressBack   = 5'(1 << BtnBack);
  localparam logic [4:0] PressSave   = 5'(1 << BtnSave);

  localparam logic [2:0] BlinkAddr = 3'(4 * RegBlinkTicks);
  localparam int unsigned IdleLimit = 5000;

  class editor_scoreboard;
    logic [3:0] blink_ticks;
    step_e      step;
    edit_t      cur;
    logic [3:0] blink_count;
    logic       blink_on;
    out_t       due_words[$];
    int unsigned errors;

    function new();
      blink_ticks = BlinkTicksRst;
      step = STEP_WEEKDAY;
      cur = '{3'd1, 5'd0, 6'd0, 6'd0, 7'd0, 4'd1, 5'd1};
      blink_count = '0;
      blink_on = 1'b0;
      errors = 0;
    endfunction

    function void take_word(in_t w);
      int unsigned lo, hi, v;
      logic shown, commit, leave;
      out_t want;
      commit = 1'b0;
      leave = 1'b0;
      shown = 1'b0;
      if (w.action == ActLoad) begin
        cur = '{w.rtc_weekday, w.rtc_hour, w.rtc_minute, w.rtc_second,
                w.rtc_year, w.rtc_month, w.rtc_date};
        step = STEP_WEEKDAY;
        blink_count = '0;
        blink_on = 1'b0;
      end else begin
        if (step <= STEP_DATE) begin
          case (step)
            STEP_WEEKDAY: begin lo = WeekdayMin; hi = WeekdayMax; v = cur.weekday; end
            STEP_HOUR:    begin lo = 0; hi = HourMax; v = cur.hour; end
            STEP_MINUTE:  begin lo = 0; hi = MinSecMax; v = cur.minute; end
            STEP_SECOND:  begin lo = 0; hi = MinSecMax; v = cur.second; end
            STEP_YEAR:    begin lo = 0; hi = YearMax; v = cur.year; end
            STEP_MONTH:   begin lo = MonthMin; hi = MonthMax; v = cur.month; end
            default: begin
              lo = DateMin;
              v = cur.date;
              case (cur.month)
                MonthApr, MonthJun, MonthSep, MonthNov: hi = DaysShort;
                MonthFeb: hi = (cur.year[1:0] == 2'b00) ? DaysLeap : DaysFeb;
                default: hi = DaysLong;
              endcase
            end
          endcase
          if (w.buttons[BtnUp]) v = (v >= hi) ? lo : v + 1;
          if (w.buttons[BtnDown]) v = (v <= lo || v > hi) ? hi : v - 1;
          case (step)
            STEP_WEEKDAY: cur.weekday = 3'(v);
            STEP_HOUR:    cur.hour = 5'(v);
            STEP_MINUTE:  cur.minute = 6'(v);
            STEP_SECOND:  cur.second = 6'(v);
            STEP_YEAR:    cur.year = 7'(v);
            STEP_MONTH:   cur.month = 4'(v);
            default:      cur.date = 5'(v);
          endcase
          if (w.buttons[BtnSwitch]) begin
            step = (step == STEP_DATE) ? STEP_WEEKDAY : step_e'(step + 1);
            blink_count = '0;
          end
          if (w.buttons[BtnBack]) step = STEP_BACK;
          if (w.buttons[BtnSave]) step = STEP_SAVE;
        end else if (step == STEP_SAVE) begin
          commit = 1'b1;
          leave = 1'b1;
          step = STEP_WEEKDAY;
        end else if (step == STEP_BACK) begin
          leave = 1'b1;
          step = STEP_WEEKDAY;
        end
        if (step <= STEP_DATE) begin
          shown = blink_on;
          if (int'(blink_count) + 1 >= int'(blink_ticks)) begin
            blink_count = '0;
            blink_on = ~blink_on;
          end else begin
            blink_count = blink_count + 4'd1;
          end
        end else begin
          shown = 1'b1;
        end
      end
      want = '{cur.weekday, cur.hour, cur.minute, cur.second, cur.year, cur.month,
               cur.date, step, shown, commit, leave};
      due_words.push_back(want);
    endfunction

    function void compare(string field, logic [6:0] want, logic [6:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_word(out_t got);
      out_t want;
      if (due_words.size() == 0) begin
        $error("result word %h with nothing expected", got);
        errors++;
        return;
      end
      want = due_words.pop_front();
      compare("weekday_value", want.weekday_value, got.weekday_value);
      compare("hour_value", want.hour_value, got.hour_value);
      compare("minute_value", want.minute_value, got.minute_value);
      compare("second_value", want.second_value, got.second_value);
      compare("year_value", want.year_value, got.year_value);
      compare("month_value", want.month_value, got.month_value);
      compare("date_value", want.date_value, got.date_value);
      compare("field_selected", want.field_selected, got.field_selected);
      compare("field_shown", want.field_shown, got.field_shown);
      compare("commit_time", want.commit_time, got.commit_time);
      compare("leave_setup", want.leave_setup, got.leave_setup);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_t        out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  editor_scoreboard board;
  bit          gap_off;
  bit          stall_off;
  int unsigned hold_request;
  int unsigned idle_cycles;

  clock_calendar_set_editor_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_t rand_word();
    logic [63:0] raw;
    in_t w;
    raw = {$urandom(), $urandom()};
    w = raw[$bits(in_t)-1:0];
    return w;
  endfunction

  function automatic in_t make_load(logic [2:0] wd, logic [4:0] hr, logic [5:0] mi,
                                    logic [5:0] se, logic [6:0] yr, logic [3:0] mo,
                                    logic [4:0] da);
    in_t w;
    w = rand_word();
    w.action = ActLoad;
    w.rtc_weekday = wd;
    w.rtc_hour = hr;
    w.rtc_minute = mi;
    w.rtc_second = se;
    w.rtc_year = yr;
    w.rtc_month = mo;
    w.rtc_date = da;
    return w;
  endfunction

  function automatic in_t make_tick(logic [4:0] press);
    in_t w;
    w = rand_word();
    w.action = ActTick;
    w.buttons = press;
    return w;
  endfunction

  function automatic in_t rand_load();
    in_t w;
    if ($urandom_range(7) == 0) begin
      w = rand_word();
      w.action = ActLoad;
      return w;
    end
    return make_load(3'($urandom_range(1, 7)), 5'($urandom_range(0, 23)),
                     6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)),
                     7'($urandom_range(0, 99)), 4'($urandom_range(1, 12)),
                     5'($urandom_range(1, 31)));
  endfunction

  function automatic logic [4:0] pick_press();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return PressUp;
    if (r < 65) return PressDown;
    if (r < 80) return PressSwitch;
    if (r < 86) return 5'd0;
    if (r < 89) return PressBack;
    if (r < 92) return PressSave;
    return 5'($urandom());
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (gap_off) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_word(input in_t w);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    board.take_word(w);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.due_words.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_blink(input logic [3:0] ticks);
    drain();
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= BlinkAddr;
    pwdata <= 32'(ticks);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.blink_ticks = ticks;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_sessions(input int unsigned count);
    int unsigned sent, ticks, burst;
    logic [4:0] press;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(19) == 0) begin
        send_word(rand_word());
        sent++;
      end else begin
        send_word(rand_load());
        sent++;
        ticks = $urandom_range(10, 70);
        while (ticks != 0 && sent < count) begin
          press = pick_press();
          burst = (press == PressUp || press == PressDown) ? $urandom_range(1, 40) : 1;
          if (burst > ticks) burst = ticks;
          ticks -= burst;
          sent += burst;
          repeat (burst) send_word(make_tick(press));
        end
        if ($urandom_range(3) != 0) begin
          send_word(make_tick($urandom_range(1) ? PressSave : PressBack));
          send_word(make_tick(5'($urandom())));
          sent += 2;
        end
      end
    end
  endtask

  initial begin : receiver
    int unsigned left, r;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) board.check_word(out_data_o);
      @(negedge clk_i);
      if (hold_request != 0) begin
        out_stall_i <= 1'b1;
        left = hold_request;
        hold_request = 0;
      end else if (left != 0) begin
        left--;
      end else begin
        r = $urandom_range(99);
        if (stall_off || r < 65) begin
          out_stall_i <= 1'b0;
          left = $urandom_range(0, 6);
        end else if (r < 95) begin
          out_stall_i <= 1'b1;
          left = $urandom_range(0, 3);
        end else begin
          out_stall_i <= 1'b1;
          left = $urandom_range(15, 40);
        end
      end
    end
  end

  initial begin
    board = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    gap_off = 1'b0;
    stall_off = 1'b0;
    hold_request = 0;
    idle_cycles = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_word(make_tick(5'd0));
    send_word(make_load(3'd1, 5'd0, 6'd0, 6'd0, 7'd0, 4'd1, 5'd1));
    send_word(make_tick(PressDown));
    send_word(make_tick(PressUp | PressDown | PressSwitch));
    send_word(make_tick(PressUp | PressSwitch | PressBack));
    send_word(make_tick(PressUp));
    send_word(make_tick(PressSwitch | PressBack | PressSave));
    send_word(make_tick(PressDown));
    send_word(make_load(3'd7, 5'd23, 6'd59, 6'd59, 7'd99, 4'd12, 5'd31));
    send_word(make_tick(PressUp));
    send_word(make_load(3'd0, 5'd24, 6'd60, 6'd60, 7'd100, 4'd13, 5'd31));
    send_word(make_tick(PressDown));
    send_word(make_tick(PressSwitch));
    send_word(make_tick(PressUp | PressSwitch));
    send_word(make_tick(PressDown | PressSwitch));
    send_word(make_tick(PressUp | PressSwitch));
    send_word(make_tick(PressDown | PressSwitch));
    send_word(make_tick(PressSwitch));
    send_word(make_tick(PressUp));
    send_word(make_tick(PressDown));
    send_word(make_load(3'd3, 5'd12, 6'd30, 6'd30, 7'd96, 4'd2, 5'd1));
    repeat (6) send_word(make_tick(PressSwitch));
    send_word(make_tick(PressDown));
    send_word(make_tick(PressUp));

    set_blink(4'd0);
    run_sessions(120);

    // hold both sides busy
    set_blink(4'd1);
    gap_off = 1'b1;
    stall_off = 1'b1;
    run_sessions(100);
    gap_off = 1'b0;
    stall_off = 1'b0;

    // hold off the output while words keep coming
    set_blink(4'd15);
    hold_request = 300;
    gap_off = 1'b1;
    run_sessions(60);
    gap_off = 1'b0;

    repeat (4) begin
      set_blink(4'($urandom_range(1, 15)));
      run_sessions(150);
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ccse_pkg.sv
rtl/ccse_cfg_regs.sv
rtl/ccse_field_unit.sv
rtl/clock_calendar_set_editor_core.sv
test/tb_top.sv
